@@ src/spp_pkg.sv @@
package spp_pkg;

    localparam int unsigned LEVEL_W = 16;
    localparam int unsigned BIN_W   = 11;
    localparam int unsigned THR_W   = 13;
    localparam int unsigned SEP_W   = 11;
    localparam int unsigned ADDR_W  = 1;

    localparam logic [ADDR_W-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [ADDR_W-1:0] REG_MIN_SEP   = 1'b1;

    localparam logic signed [THR_W-1:0] THRESHOLD_RESET = -13'sd880;
    localparam logic [SEP_W-1:0]        MIN_SEP_RESET   = 11'd4;

    typedef struct packed {
        logic [BIN_W-1:0]          peak_bin;
        logic signed [LEVEL_W-1:0] peak_level;
        logic                      found;
        logic                      last;
    } t_result;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic                      last_bin;
    } t_bin_item;

endpackage

@@ src/spp_stream_if.sv @@
interface spp_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ src/spp_sel_unit.sv @@
// selection sequencer: repeated scans of the candidate memory for the largest
// unpicked level, then a scan of the kept list for separation
module spp_sel_unit #(
    parameter int unsigned CANDIDATE_DEPTH = 1024,
    parameter int unsigned MAX_PEAKS       = 20
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [$clog2(CANDIDATE_DEPTH+1)-1:0]   i_cand_count,
    input  logic [spp_pkg::SEP_W-1:0]              i_min_sep,
    // candidate memory read port
    output logic [$clog2(CANDIDATE_DEPTH)-1:0]     o_rd_addr,
    input  logic [spp_pkg::BIN_W-1:0]              i_rd_bin,
    input  logic signed [spp_pkg::LEVEL_W-1:0]     i_rd_level,
    // results
    output logic                                   o_busy,
    spp_stream_if.source                           o_res
);
    localparam int unsigned CA_W = $clog2(CANDIDATE_DEPTH);
    localparam int unsigned CC_W = $clog2(CANDIDATE_DEPTH+1);
    localparam int unsigned KA_W = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
    localparam int unsigned KC_W = $clog2(MAX_PEAKS+1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_CHECK, S_EMIT, S_NONE
    } t_state;

    t_state                          r_state;
    logic [CC_W-1:0]                 r_idx;     // scan address, one ahead of data
    logic                            r_dv;
    logic [CA_W-1:0]                 r_didx;
    logic                            r_have;
    logic [CA_W-1:0]                 r_best;
    logic [spp_pkg::BIN_W-1:0]       r_best_bin;
    logic signed [spp_pkg::LEVEL_W-1:0] r_best_lvl;
    logic [CC_W-1:0]                 r_picks;
    logic                            r_pany;
    logic signed [spp_pkg::LEVEL_W-1:0] r_plvl;
    logic [CA_W-1:0]                 r_pidx;
    logic [spp_pkg::BIN_W-1:0]       r_kbin [MAX_PEAKS];
    logic signed [spp_pkg::LEVEL_W-1:0] r_klvl [MAX_PEAKS];
    logic [KC_W-1:0]                 r_kcnt;
    logic [KC_W-1:0]                 r_k;
    logic                            r_near;
    logic [CC_W-1:0]                 r_count;
    logic                            r_valid;
    spp_pkg::t_result                r_out;

    logic [spp_pkg::BIN_W-1:0] w_dist;
    logic [spp_pkg::BIN_W-1:0] w_kb;
    logic                      w_unpicked;

    assign o_rd_addr = r_idx[CA_W-1:0];
    assign o_busy    = (r_state != S_IDLE) || r_valid;
    assign o_res.valid   = r_valid;
    assign o_res.payload = r_out;

    assign w_kb   = r_kbin[r_k[KA_W-1:0]];
    assign w_dist = (r_best_bin > w_kb) ? r_best_bin - w_kb : w_kb - r_best_bin;

    // picks run in (level down, address up) order, so anything ranked after
    // the previous pick is still unpicked
    assign w_unpicked = !r_pany || (i_rd_level < r_plvl) ||
                        ((i_rd_level == r_plvl) && (r_didx > r_pidx));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_pany  <= 1'b0;
            r_kcnt  <= '0;
            r_dv    <= 1'b0;
        end else begin
            if (r_valid && o_res.ready && r_state != S_EMIT && r_state != S_NONE)
                r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_count <= i_cand_count;
                        r_picks <= '0;
                        r_kcnt  <= '0;
                        r_pany  <= 1'b0;
                        r_idx   <= '0;
                        r_dv    <= 1'b0;
                        r_have  <= 1'b0;
                        if (i_cand_count == '0)
                            r_state <= S_NONE;
                        else
                            r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // read data comes back in the cycle after its address
                    r_dv   <= (r_idx < r_count);
                    r_didx <= r_idx[CA_W-1:0];
                    if (r_idx < r_count)
                        r_idx <= r_idx + 1'b1;
                    if (r_dv && w_unpicked &&
                        (!r_have || i_rd_level > r_best_lvl)) begin
                        r_have     <= 1'b1;
                        r_best     <= r_didx;
                        r_best_bin <= i_rd_bin;
                        r_best_lvl <= i_rd_level;
                    end
                    if (r_idx >= r_count && !r_dv) begin
                        r_k    <= '0;
                        r_near <= 1'b0;
                        if (r_have) begin
                            r_pany  <= 1'b1;
                            r_plvl  <= r_best_lvl;
                            r_pidx  <= r_best;
                            r_picks <= r_picks + 1'b1;
                            r_state <= S_CHECK;
                        end else begin
                            r_state <= (r_kcnt == '0) ? S_NONE : S_EMIT;
                        end
                    end
                end
                S_CHECK: begin
                    if (r_k < r_kcnt) begin
                        if (w_dist < i_min_sep)
                            r_near <= 1'b1;
                        r_k <= r_k + 1'b1;
                    end else begin
                        logic [KC_W-1:0] v_cnt;
                        v_cnt = r_kcnt;
                        if (!r_near) begin
                            r_kbin[r_kcnt[KA_W-1:0]] <= r_best_bin;
                            r_klvl[r_kcnt[KA_W-1:0]] <= r_best_lvl;
                            v_cnt = r_kcnt + 1'b1;
                        end
                        r_kcnt <= v_cnt;
                        r_idx  <= '0;
                        r_dv   <= 1'b0;
                        r_have <= 1'b0;
                        r_k    <= '0;
                        if (v_cnt == KC_W'(MAX_PEAKS) || r_picks >= r_count)
                            r_state <= (v_cnt == '0) ? S_NONE : S_EMIT;
                        else
                            r_state <= S_SCAN;
                    end
                end
                S_EMIT: begin
                    if (!r_valid || o_res.ready) begin
                        r_valid          <= 1'b1;
                        r_out.peak_bin   <= r_kbin[r_k[KA_W-1:0]];
                        r_out.peak_level <= r_klvl[r_k[KA_W-1:0]];
                        r_out.found      <= 1'b1;
                        r_out.last       <= (r_k + 1'b1 == r_kcnt);
                        r_k <= r_k + 1'b1;
                        if (r_k + 1'b1 == r_kcnt)
                            r_state <= S_IDLE;
                    end
                end
                S_NONE: begin
                    if (!r_valid || o_res.ready) begin
                        r_valid <= 1'b1;
                        r_out   <= '{peak_bin: '0, peak_level: '0, found: 1'b0,
                                     last: 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ src/spectrum_peak_picker.sv @@
// Spectrum peak picker. Bins stream in at one per cycle (ready stays high
// during a sweep); an interior bin at or above the threshold, at or above its
// left neighbour and strictly above its right is stored as a candidate. After
// the last bin the block drops ready and runs a selection pass: each pick is a
// full scan of the candidate memory followed by a separation check against
// the kept list. Results leave through an output register; peaks come in
// descending level, ties to the lower bin, and a sweep without peaks gives
// one result with found low. Registers: 0x0 threshold_level, 0x4
// min_separation_bins.
module spectrum_peak_picker #(
    parameter int unsigned MAX_BINS        = 2048,
    parameter int unsigned MAX_PEAKS       = 20,
    parameter int unsigned CANDIDATE_DEPTH = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    spp_stream_if.sink   i_bin,
    spp_stream_if.source o_peak,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int unsigned CA_W = $clog2(CANDIDATE_DEPTH);
    localparam int unsigned CC_W = $clog2(CANDIDATE_DEPTH+1);
    localparam int unsigned BC_W = $clog2(MAX_BINS);

    function automatic logic signed [spp_pkg::LEVEL_W-1:0] LEVEL_W_SEXT(
        input logic signed [spp_pkg::THR_W-1:0] v);
        return spp_pkg::LEVEL_W'(v);
    endfunction

    logic signed [spp_pkg::THR_W-1:0]   r_thr;
    logic [spp_pkg::SEP_W-1:0]          r_sep;
    logic signed [spp_pkg::LEVEL_W-1:0] r_prev, r_older;
    logic [BC_W-1:0]                    r_bcnt;
    logic                               r_full;
    logic [CC_W-1:0]                    r_ccnt;
    logic                               r_start;
    logic [spp_pkg::BIN_W+spp_pkg::LEVEL_W-1:0] r_mem [CANDIDATE_DEPTH];
    logic [spp_pkg::BIN_W+spp_pkg::LEVEL_W-1:0] r_rd;
    logic [CA_W-1:0]                    w_rd_addr;
    logic                               w_busy;
    logic                               w_acc;
    logic                               w_cand;
    logic signed [spp_pkg::LEVEL_W-1:0] w_cur;

    assign pready = 1'b1;
    assign i_bin.ready = !w_busy && !r_start;
    assign w_acc = i_bin.valid && i_bin.ready;
    assign w_cur = i_bin.payload.level;
    assign w_cand = !r_full && (r_bcnt >= BC_W'(2)) &&
                    (r_prev >= LEVEL_W_SEXT(r_thr)) && (r_prev >= r_older) &&
                    (r_prev > w_cur) && (r_ccnt < CC_W'(CANDIDATE_DEPTH));

    always_comb begin
        prdata = '0;
        case (paddr[2:2])
            spp_pkg::REG_THRESHOLD: prdata = {{(32-spp_pkg::THR_W){r_thr[spp_pkg::THR_W-1]}}, r_thr};
            spp_pkg::REG_MIN_SEP:   prdata = {{(32-spp_pkg::SEP_W){1'b0}}, r_sep};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_cand)
            r_mem[r_ccnt[CA_W-1:0]] <= {spp_pkg::BIN_W'(r_bcnt - 1'b1), r_prev};
        r_rd <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= spp_pkg::THRESHOLD_RESET;
            r_sep   <= spp_pkg::MIN_SEP_RESET;
            r_prev  <= '0;
            r_older <= '0;
            r_bcnt  <= '0;
            r_full  <= 1'b0;
            r_ccnt  <= '0;
            r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (psel && penable && pwrite) begin
                if (paddr[2:2] == spp_pkg::REG_THRESHOLD)
                    r_thr <= pwdata[spp_pkg::THR_W-1:0];
                else if (paddr[2:2] == spp_pkg::REG_MIN_SEP)
                    r_sep <= pwdata[spp_pkg::SEP_W-1:0];
            end
            if (w_acc) begin
                if (i_bin.payload.last_bin) begin
                    // sweep state clears, selection gets the count
                    r_start <= 1'b1;
                    r_prev  <= '0;
                    r_older <= '0;
                    r_bcnt  <= '0;
                    r_full  <= 1'b0;
                end else if (!r_full) begin
                    r_older <= r_prev;
                    r_prev  <= w_cur;
                    if (r_bcnt == BC_W'(MAX_BINS - 1))
                        r_full <= 1'b1;
                    else
                        r_bcnt <= r_bcnt + 1'b1;
                end
                if (w_cand)
                    r_ccnt <= r_ccnt + 1'b1;
            end
            if (r_start)
                r_ccnt <= '0;
        end
    end

    // candidate count is taken in the cycle after the last bin, once it has settled
    spp_sel_unit #(
        .CANDIDATE_DEPTH(CANDIDATE_DEPTH),
        .MAX_PEAKS      (MAX_PEAKS)
    ) u_sel (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_start),
        .i_cand_count(r_ccnt),
        .i_min_sep   (r_sep),
        .o_rd_addr   (w_rd_addr),
        .i_rd_bin    (r_rd[spp_pkg::BIN_W+spp_pkg::LEVEL_W-1:spp_pkg::LEVEL_W]),
        .i_rd_level  (r_rd[spp_pkg::LEVEL_W-1:0]),
        .o_busy      (w_busy),
        .o_res       (o_peak)
    );
endmodule

@@ src/spp_checker.sv @@
module spp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_found,
    input logic        out_last
);
    // ready drops once the last bin is taken, as the selection pass begins
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_last |=> !in_ready) else $error("ready after last bin");
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_found |-> out_last) else $error("empty result not last");
    a_no_out_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("result during sweep");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

bind spectrum_peak_picker spp_checker u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .in_valid (i_bin.valid),
    .in_ready (i_bin.ready),
    .in_last  (i_bin.payload.last_bin),
    .out_valid(o_peak.valid),
    .out_ready(o_peak.ready),
    .out_found(o_peak.payload.found),
    .out_last (o_peak.payload.last)
);

@@ dv/spp_peak_checker.sv @@
`timescale 1ns / 100ps

module spp_peak_checker
    import spp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    spp_stream_if       bin_if,
    spp_stream_if       peak_if,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_sweeps,
    output int          o_peaks_seen
);

    localparam int NUM_BINS   = 2048;
    localparam int PEAK_LIMIT = 20;
    localparam int CAND_DEPTH = 1024;

    logic [THR_W-1:0] thr_reg;
    logic [SEP_W-1:0] sep_reg;

    int           prev_lvl;
    int           older_lvl;
    int           bin_cnt;
    bit           bins_full;
    int           cand_bin [CAND_DEPTH];
    int           cand_lvl [CAND_DEPTH];
    bit           picked   [CAND_DEPTH];
    int           cand_cnt;
    t_result      expected_peaks [$];

    // non-maximum suppression over the stored candidates, queues the results
    task automatic pick_peaks();
        int       kept_bin [PEAK_LIMIT];
        int       kept_lvl [PEAK_LIMIT];
        int       kept;
        int       picks;
        int       best;
        int       gap;
        bit       near;
        t_result  r;
        kept  = 0;
        picks = 0;
        while (kept < PEAK_LIMIT && picks < cand_cnt) begin
            best = -1;
            for (int i = 0; i < cand_cnt; i++) begin
                if (!picked[i] && (best < 0 || cand_lvl[i] > cand_lvl[best])) best = i;
            end
            if (best < 0) break;
            picked[best] = 1'b1;
            picks++;
            near = 1'b0;
            for (int k = 0; k < kept; k++) begin
                gap = cand_bin[best] > kept_bin[k] ? cand_bin[best] - kept_bin[k]
                                                   : kept_bin[k] - cand_bin[best];
                if (gap < int'(sep_reg)) near = 1'b1;
            end
            if (!near) begin
                kept_bin[kept] = cand_bin[best];
                kept_lvl[kept] = cand_lvl[best];
                kept++;
            end
        end
        if (kept == 0) begin
            r = '0;
            r.last = 1'b1;
            expected_peaks.insert(expected_peaks.size(), r);
        end else begin
            for (int k = 0; k < kept; k++) begin
                r.peak_bin   = kept_bin[k][BIN_W-1:0];
                r.peak_level = kept_lvl[k][LEVEL_W-1:0];
                r.found      = 1'b1;
                r.last       = (k == kept - 1);
                expected_peaks.insert(expected_peaks.size(), r);
            end
        end
    endtask

    task automatic clear_sweep();
        prev_lvl  = 0;
        older_lvl = 0;
        bin_cnt   = 0;
        bins_full = 1'b0;
        cand_cnt  = 0;
        for (int i = 0; i < CAND_DEPTH; i++) picked[i] = 1'b0;
    endtask

    task automatic take_bin(input t_bin_item it);
        int cur;
        int thr;
        cur = int'(it.level);
        thr = int'($signed(thr_reg));
        if (!bins_full) begin
            if (bin_cnt >= 2 && prev_lvl >= thr && prev_lvl >= older_lvl && prev_lvl > cur
                && cand_cnt < CAND_DEPTH) begin
                cand_bin[cand_cnt] = bin_cnt - 1;
                cand_lvl[cand_cnt] = prev_lvl;
                cand_cnt++;
            end
            older_lvl = prev_lvl;
            prev_lvl  = cur;
            if (bin_cnt >= NUM_BINS - 1) bins_full = 1'b1;
            else bin_cnt++;
        end
        if (it.last_bin) begin
            pick_peaks();
            clear_sweep();
            o_sweeps++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            thr_reg = THRESHOLD_RESET;
            sep_reg = MIN_SEP_RESET;
            clear_sweep();
            expected_peaks.delete();
            o_mismatches = 0;
            o_sweeps     = 0;
            o_peaks_seen = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2:2] == REG_THRESHOLD) thr_reg = pwdata[THR_W-1:0];
                else if (paddr[2:2] == REG_MIN_SEP) sep_reg = pwdata[SEP_W-1:0];
            end
            if (peak_if.valid && peak_if.ready) begin
                got = peak_if.payload;
                o_peaks_seen++;
                if (expected_peaks.size() == 0) begin
                    $display("%0t: unexpected result bin %0d level %0d found %0b last %0b",
                             $time, got.peak_bin, got.peak_level, got.found, got.last);
                    o_mismatches++;
                end else begin
                    want = expected_peaks.pop_front();
                    if (got.peak_bin !== want.peak_bin) begin
                        $display("%0t: peak_bin expected %0d actual %0d",
                                 $time, want.peak_bin, got.peak_bin);
                        o_mismatches++;
                    end
                    if (got.peak_level !== want.peak_level) begin
                        $display("%0t: peak_level expected %0d actual %0d",
                                 $time, want.peak_level, got.peak_level);
                        o_mismatches++;
                    end
                    if (got.found !== want.found) begin
                        $display("%0t: found expected %0b actual %0b",
                                 $time, want.found, got.found);
                        o_mismatches++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, got.last);
                        o_mismatches++;
                    end
                end
            end
            if (bin_if.valid && bin_if.ready) take_bin(bin_if.payload);
        end
        o_pending = expected_peaks.size();
    end

endmodule

@@ dv/spectrum_peak_picker_test.sv @@
`timescale 1ns / 100ps

module spectrum_peak_picker_test;
    import spp_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending;
    int sweeps;
    int peaks_seen;

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_now;
    int thr_now;

    spp_stream_if #(.t_payload(t_bin_item)) bin_if ();
    spp_stream_if #(.t_payload(t_result))   peak_if ();

    spectrum_peak_picker u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bin   (bin_if),
        .o_peak  (peak_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    spp_peak_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .bin_if       (bin_if),
        .peak_if      (peak_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_sweeps     (sweeps),
        .o_peaks_seen (peaks_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("timeout waiting for results");
        $display("Some tests failed");
        $finish;
    end

    // result side: random back-pressure plus one long hold-off
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        peak_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_now && !hold_done) begin
                peak_if.ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                hold_done = 1'b1;
            end
            peak_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic reg_write(input logic [ADDR_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_THRESHOLD) thr_now = int'($signed(val[THR_W-1:0]));
    endtask

    task automatic send_bin(input logic signed [LEVEL_W-1:0] lvl, input logic last_bin);
        t_bin_item it;
        it.level    = lvl;
        it.last_bin = last_bin;
        while ($urandom_range(99) < send_idle_pct) begin
            bin_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        bin_if.valid   <= 1'b1;
        bin_if.payload <= it;
        do @(posedge i_clk); while (!bin_if.ready);
    endtask

    task automatic send_sweep(input int len, input int shape);
        int lvl;
        int base;
        for (int i = 0; i < len; i++) begin
            case (shape)
                0: lvl = $signed(16'($urandom()));
                1: begin
                    base = thr_now + $signed($urandom_range(600)) - 300;
                    lvl  = base;
                end
                default: lvl = thr_now + 40 * $signed($urandom_range(4));
            endcase
            if (lvl > 32767) lvl = 32767;
            if (lvl < -32768) lvl = -32768;
            send_bin(16'(lvl), i == len - 1);
        end
    endtask

    // advance the clock first so the checker has queued what the last request causes
    task automatic wait_drained();
        bin_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic random_sweeps(input int budget);
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(99);
            if (pick < 8) len = $urandom_range(1, 2);
            else if (pick < 88) len = $urandom_range(3, 30);
            else len = $urandom_range(31, 90);
            send_sweep(len, $urandom_range(9) < 2 ? 0 : ($urandom_range(9) < 6 ? 1 : 2));
            sent += len;
        end
    endtask

    initial begin
        logic signed [LEVEL_W-1:0] edge_lvls [7];
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        bin_if.valid   = 1'b0;
        bin_if.payload = '0;
        send_idle_pct  = 9;
        recv_idle_pct  = 76;
        hold_now       = 1'b0;
        thr_now        = -880;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: short sweeps, extremes, ties and nothing above threshold
        send_bin(16'sd100, 1'b1);
        send_bin(16'sd0, 1'b0);
        send_bin(16'sd500, 1'b1);
        edge_lvls = '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767,
                      -16'sd1, 16'sd5};
        foreach (edge_lvls[i]) send_bin(edge_lvls[i], i == 6);
        send_bin(16'sd0, 1'b0);
        send_bin(16'sd10, 1'b0);
        send_bin(16'sd5, 1'b0);
        send_bin(16'sd10, 1'b0);
        send_bin(16'sd5, 1'b1);
        send_bin(-16'sd2000, 1'b0);
        send_bin(-16'sd1000, 1'b0);
        send_bin(-16'sd1500, 1'b1);
        wait_drained();

        reg_write(REG_THRESHOLD, 32'hFFFF_F6A0);
        reg_write(REG_MIN_SEP, 32'd2047);
        random_sweeps(60);
        wait_drained();
        reg_write(REG_THRESHOLD, 32'd0);
        reg_write(REG_MIN_SEP, 32'd3);
        random_sweeps(60);
        wait_drained();

        send_idle_pct = 76;
        recv_idle_pct = 9;
        reg_write(REG_THRESHOLD, 32'h0FFF);
        reg_write(REG_MIN_SEP, 32'd0);
        random_sweeps(40);
        wait_drained();
        reg_write(REG_THRESHOLD, 32'($signed($urandom_range(2400)) * -1));
        reg_write(REG_MIN_SEP, 32'($urandom_range(3, 40)));
        random_sweeps(70);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        reg_write(REG_THRESHOLD, 32'hFFFF_F6A0);
        reg_write(REG_MIN_SEP, 32'd1);
        hold_now = 1'b1;
        random_sweeps(60);
        wait_drained();
        reg_write(REG_THRESHOLD, 32'hFFFF_FC90);
        reg_write(REG_MIN_SEP, 32'd4);
        random_sweeps(60);
        wait_drained();

        $display("covered %0d sweeps and %0d results over several threshold and separation",
                 sweeps, peaks_seen);
        $display("settings, with input and output back-pressure and a long result hold-off");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
